FILE: rtl/c_comment_stripper_top_defines.svh
// Assertion macros shared by the comment stripper RTL.
`ifndef C_COMMENT_STRIPPER_TOP_DEFINES_SVH
`define C_COMMENT_STRIPPER_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define CCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define CCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ccstrip_pkg.sv
// Shared types and constants for the comment stripper.
package ccstrip_pkg;

  localparam int UNIT_WIDTH = 16;

  // Character codes, sized to one unit.
  localparam logic [UNIT_WIDTH-1:0] CH_SLASH   = UNIT_WIDTH'('h2F);
  localparam logic [UNIT_WIDTH-1:0] CH_STAR    = UNIT_WIDTH'('h2A);
  localparam logic [UNIT_WIDTH-1:0] CH_NEWLINE = UNIT_WIDTH'('h0A);
  localparam logic [UNIT_WIDTH-1:0] CH_SPACE   = UNIT_WIDTH'('h20);

  // Output queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  // Level at or below which two more beats still fit.
  localparam logic [QCNT_W-1:0] QROOM_LIMIT = QCNT_W'(QDEPTH - 2);

  // Scanner mode.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STAR   = 3'd4
  } mode_t;

  // One queued result beat.
  typedef struct packed {
    logic [UNIT_WIDTH-1:0] unit;
    logic                  fin;
  } entry_t;

  // Results of one scanner step, also the queue push group.
  typedef struct packed {
    logic [1:0] n;
    entry_t     e0;
    entry_t     e1;
  } push_t;

  // Queue status back to the top level.
  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage

FILE: rtl/c_comment_stripper_top.sv
// Top level of the streaming C comment stripper.
//
//   channel | direction | beat payload            | handshake
//   input   | in        | code_unit, end_of_text  | in_valid / in_ready
//   output  | out       | out_unit, final_unit    | out_valid / out_ready
//
// One input beat per cycle; each makes zero, one or two output beats.
// Each input beat passes through the input register, then the output
// queue. The output side moves one beat per cycle while out_ready is high,
// so the two beats of one item leave one after the other.
// Input stalls when the four-entry output queue holds more than two beats.
// Reset (rst, synchronous) empties both stages and returns to normal mode.
`include "c_comment_stripper_top_defines.svh"

module c_comment_stripper_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ccstrip_pkg::UNIT_WIDTH-1:0] code_unit,
  input  logic                               end_of_text,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ccstrip_pkg::UNIT_WIDTH-1:0] out_unit,
  output logic                               final_unit
);

  logic                               ir_valid;
  logic [ccstrip_pkg::UNIT_WIDTH-1:0] ir_unit;
  logic                               ir_last;
  ccstrip_pkg::mode_t                 mode;
  ccstrip_pkg::mode_t                 mode_next;
  ccstrip_pkg::push_t                 step_res;
  ccstrip_pkg::push_t                 push;
  ccstrip_pkg::qstat_t                qstat;
  logic                               adv;
  logic                               in_acc;

  // Item moves on when the queue has room for two beats
  assign adv      = ir_valid && (qstat.count <= ccstrip_pkg::QROOM_LIMIT);
  assign in_ready = !ir_valid || adv;
  assign in_acc   = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_acc) begin
      ir_valid <= 1'b1;
    end else if (adv) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ir_unit <= code_unit;
      ir_last <= end_of_text;
    end
  end

  // Scanner mode
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ccstrip_pkg::MODE_NORMAL;
    end else if (adv) begin
      mode <= mode_next;
    end
  end

  ccstrip_step u_step (
    .mode      (mode),
    .unit      (ir_unit),
    .last      (ir_last),
    .mode_next (mode_next),
    .res       (step_res)
  );

  always_comb begin
    push   = step_res;
    push.n = adv ? step_res.n : 2'd0;
  end

  ccstrip_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .stat       (qstat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_unit   (out_unit),
    .final_unit (final_unit)
  );

  // Checks
  `CCS_ASSERT_NOW(a_last_emits, adv && ir_last, step_res.n != 2'd0, "end of text with no beat")
  `CCS_ASSERT_NEXT(a_last_resets_mode, adv && ir_last, mode == ccstrip_pkg::MODE_NORMAL, "mode not normal after end")
  `CCS_ASSERT_NOW(a_pair_source, adv && step_res.n == 2'd2, mode == ccstrip_pkg::MODE_LINE || mode == ccstrip_pkg::MODE_SLASH, "two beats from wrong mode")
  `CCS_ASSERT_NOW(a_queue_bound, 1'b1, qstat.count <= ccstrip_pkg::QCNT_W'(ccstrip_pkg::QDEPTH), "output queue overflow")

endmodule

FILE: rtl/ccstrip_step.sv
// Combinational scanner step: mode transition and up to two result units.
module ccstrip_step (
  input  ccstrip_pkg::mode_t                 mode,
  input  logic [ccstrip_pkg::UNIT_WIDTH-1:0] unit,
  input  logic                               last,
  output ccstrip_pkg::mode_t                 mode_next,
  output ccstrip_pkg::push_t                 res
);

  logic                               is_slash;
  logic                               is_star;
  logic                               is_nl;
  logic [1:0]                         n;
  logic [ccstrip_pkg::UNIT_WIDTH-1:0] u0;
  logic [ccstrip_pkg::UNIT_WIDTH-1:0] u1;
  ccstrip_pkg::mode_t                 m;

  assign is_slash = (unit == ccstrip_pkg::CH_SLASH);
  assign is_star  = (unit == ccstrip_pkg::CH_STAR);
  assign is_nl    = (unit == ccstrip_pkg::CH_NEWLINE);

  // Per-mode transition
  always_comb begin
    n  = 2'd0;
    u0 = ccstrip_pkg::CH_SPACE;
    u1 = unit;
    m  = mode;
    case (mode)
      ccstrip_pkg::MODE_SLASH: begin
        if (is_slash || is_star) begin
          if (last) begin
            n = 2'd1;
          end else begin
            m = is_slash ? ccstrip_pkg::MODE_LINE : ccstrip_pkg::MODE_BLOCK;
          end
        end else begin
          // held slash goes out, then the unit as plain text
          n  = 2'd2;
          u0 = ccstrip_pkg::CH_SLASH;
          u1 = unit;
          m  = ccstrip_pkg::MODE_NORMAL;
        end
      end
      ccstrip_pkg::MODE_LINE: begin
        if (is_nl) begin
          n  = 2'd2;
          u1 = ccstrip_pkg::CH_NEWLINE;
          m  = ccstrip_pkg::MODE_NORMAL;
        end else if (last) begin
          n = 2'd1;
        end
      end
      ccstrip_pkg::MODE_BLOCK, ccstrip_pkg::MODE_STAR: begin
        if (mode == ccstrip_pkg::MODE_STAR && is_slash) begin
          n = 2'd1;
          m = ccstrip_pkg::MODE_NORMAL;
        end else if (last) begin
          n = 2'd1;
        end else begin
          if (is_nl) begin
            n  = 2'd1;
            u0 = ccstrip_pkg::CH_NEWLINE;
          end
          m = is_star ? ccstrip_pkg::MODE_STAR : ccstrip_pkg::MODE_BLOCK;
        end
      end
      default: begin
        if (is_slash && !last) begin
          m = ccstrip_pkg::MODE_SLASH;
        end else begin
          n  = 2'd1;
          u0 = unit;
          m  = ccstrip_pkg::MODE_NORMAL;
        end
      end
    endcase
  end

  // End of text forces normal mode and marks the last result
  assign mode_next   = last ? ccstrip_pkg::MODE_NORMAL : m;
  assign res.n       = n;
  assign res.e0.unit = u0;
  assign res.e0.fin  = last && (n == 2'd1);
  assign res.e1.unit = u1;
  assign res.e1.fin  = last && (n == 2'd2);

endmodule

FILE: rtl/ccstrip_outq.sv
// Small output queue: up to two beats in per cycle, one beat out.
module ccstrip_outq (
  input  logic                               clk,
  input  logic                               rst,
  input  ccstrip_pkg::push_t                 push,
  output ccstrip_pkg::qstat_t                stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ccstrip_pkg::UNIT_WIDTH-1:0] out_unit,
  output logic                               final_unit
);

  ccstrip_pkg::entry_t                    slots [ccstrip_pkg::QDEPTH];
  logic [ccstrip_pkg::QPTR_W-1:0]         head;
  logic [ccstrip_pkg::QPTR_W-1:0]         tail;
  logic [ccstrip_pkg::QCNT_W-1:0]         count;
  logic [ccstrip_pkg::QCNT_W-1:0]         count_next;
  logic [ccstrip_pkg::QPTR_W-1:0]         tail_p1;
  logic                                   pop;

  assign pop        = out_valid && out_ready;
  assign tail_p1    = tail + ccstrip_pkg::QPTR_W'(1);
  assign count_next = count + ccstrip_pkg::QCNT_W'(push.n)
                    - ccstrip_pkg::QCNT_W'(pop);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + ccstrip_pkg::QPTR_W'(push.n);
      head  <= head + ccstrip_pkg::QPTR_W'(pop);
      count <= count_next;
    end
  end

  // Slot writes, no reset on payload
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      slots[tail] <= push.e0;
    end
    if (push.n == 2'd2) begin
      slots[tail_p1] <= push.e1;
    end
  end

  assign out_valid  = (count != '0);
  assign out_unit   = slots[head].unit;
  assign final_unit = slots[head].fin;
  assign stat.count = count;

endmodule
